// File: hw/rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants of the first-fit run allocator
// Request and response beat layouts, opcodes and configuration register map.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam logic [0:0] OP_ALLOC = 1'b0;
    localparam logic [0:0] OP_FREE  = 1'b1;

    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_ROW_WIDTH = 1'b0;

    localparam logic [7:0] ROW_WIDTH_RESET = 8'd128;

    typedef struct packed {
        logic [0:0] opcode;
        logic [7:0] owner_id;
        logic [7:0] run_length;
    } req_t;

    typedef struct packed {
        logic [6:0] start_slot;
        logic       failed;
    } rsp_t;

endpackage

// File: hw/rtl/ffra_slot_ram.sv
// ----------------------------------------------------------------------------
// ffra_slot_ram: slot store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffra_slot_ram #(
    parameter int DEPTH  = 128,
    parameter int DATA_W = 9,
    parameter int ADDR_W = 7
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hw/rtl/ffra_apb_regs.sv
// ----------------------------------------------------------------------------
// ffra_apb_regs: configuration registers
// APB-style write and read access to the row width register.
// ----------------------------------------------------------------------------
module ffra_apb_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ffra_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [7:0]                     row_width
);
    import ffra_pkg::*;

    logic [7:0]           row_width_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_hit;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_hit  = psel && penable && pwrite && pready && (reg_idx == REG_ROW_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
        end
        else if (wr_hit)
        begin
            row_width_reg <= pwdata[7:0];
        end
    end

    assign prdata    = (reg_idx == REG_ROW_WIDTH) ? {24'd0, row_width_reg} : 32'd0;
    assign row_width = row_width_reg;

endmodule

// File: hw/rtl/first_fit_run_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_run_allocator_top: first-fit contiguous run allocator
// Sequencer that scans the slot store one slot per cycle and marks runs.
// ----------------------------------------------------------------------------
// After reset the block clears all MAX_SLOTS slots of the slot store, and no
// request beat is taken during that pass. W is the active row width. A free
// request scans W slots and clears each one its owner holds, and an allocate
// that fails scans all W. A successful allocate ends its scan at the last
// slot e of the run it places, then marks each slot of that run. An allocate
// of length zero goes straight to its done state. A response beat that still
// waits for rsp_ready holds the next allocate in its done state until that
// beat is taken. The scan is bound by the single read port of the slot store,
// which it reads one slot per cycle. A free request returns no response beat.
module first_fit_run_allocator_top #(
    parameter int MAX_SLOTS = 128,
    parameter int ID_BITS   = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ffra_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  ffra_pkg::req_t                 req_data,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output ffra_pkg::rsp_t                 rsp_data
);
    import ffra_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int EXT_W  = (CNT_W > 8) ? CNT_W : 8;
    localparam int DATA_W = ID_BITS + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_DONE
    } state_t;

    state_t             state_reg,      state_next;
    logic [0:0]         op_reg,         op_next;
    logic [ID_BITS-1:0] id_reg,         id_next;
    logic [7:0]         len_reg,        len_next;
    logic [CNT_W-1:0]   rd_idx_reg,     rd_idx_next;
    logic               rd_valid_reg,   rd_valid_next;
    logic [IDX_W-1:0]   rd_addr_reg,    rd_addr_next;
    logic [EXT_W-1:0]   run_reg,        run_next;
    logic [IDX_W-1:0]   mark_idx_reg,   mark_idx_next;
    logic [IDX_W-1:0]   mark_end_reg,   mark_end_next;
    logic [IDX_W-1:0]   clr_idx_reg,    clr_idx_next;
    logic [6:0]         res_start_reg,  res_start_next;
    logic               res_failed_reg, res_failed_next;
    logic               rsp_valid_reg,  rsp_valid_next;
    rsp_t               rsp_data_reg,   rsp_data_next;

    logic [7:0]         row_width;
    logic [EXT_W-1:0]   row_width_ext;
    logic [CNT_W-1:0]   w_cnt;
    logic [EXT_W-1:0]   len_ext;
    logic [EXT_W-1:0]   run_step;
    logic [EXT_W-1:0]   start_ext;
    logic               issue;
    logic               slot_busy;
    logic [ID_BITS-1:0] slot_owner;

    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [DATA_W-1:0]  ram_wr_data;
    logic [DATA_W-1:0]  ram_rd_data;

    ffra_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .row_width (row_width)
    );

    ffra_slot_ram #(
        .DEPTH  (MAX_SLOTS),
        .DATA_W (DATA_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign row_width_ext = EXT_W'(row_width);
    assign w_cnt         = (row_width_ext > EXT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                               : row_width_ext[CNT_W-1:0];
    assign len_ext       = EXT_W'(len_reg);
    assign slot_busy     = ram_rd_data[ID_BITS];
    assign slot_owner    = ram_rd_data[ID_BITS-1:0];
    assign run_step      = slot_busy ? '0 : (run_reg + EXT_W'(1));
    assign start_ext     = EXT_W'(rd_addr_reg) + EXT_W'(1) - len_ext;
    assign issue         = (state_reg == ST_SCAN) && (rd_idx_reg != w_cnt);

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        len_next        = len_reg;
        rd_idx_next     = rd_idx_reg;
        rd_valid_next   = 1'b0;
        rd_addr_next    = rd_addr_reg;
        run_next        = run_reg;
        mark_idx_next   = mark_idx_reg;
        mark_end_next   = mark_end_reg;
        clr_idx_next    = clr_idx_reg;
        res_start_next  = res_start_reg;
        res_failed_next = res_failed_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_data_next   = rsp_data_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = rd_addr_reg;
        ram_wr_data     = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_idx_reg;
                ram_wr_data  = '0;
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == IDX_W'(MAX_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next         = req_data.opcode;
                    id_next         = ID_BITS'(req_data.owner_id);
                    len_next        = req_data.run_length;
                    rd_idx_next     = '0;
                    run_next        = '0;
                    res_start_next  = '0;
                    res_failed_next = 1'b0;
                    if ((req_data.opcode == OP_ALLOC) && (req_data.run_length == 8'd0))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_valid_next = 1'b1;
                    rd_addr_next  = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                end
                if (op_reg == OP_FREE)
                begin
                    if (rd_valid_reg && slot_busy && (slot_owner == id_reg))
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = rd_addr_reg;
                        ram_wr_data = '0;
                    end
                    if (!issue && !rd_valid_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (rd_valid_reg && (run_step == len_ext))
                begin
                    run_next       = run_step;
                    rd_valid_next  = 1'b0;
                    mark_idx_next  = start_ext[IDX_W-1:0];
                    mark_end_next  = rd_addr_reg;
                    res_start_next = start_ext[6:0];
                    state_next     = ST_MARK;
                end
                else
                begin
                    if (rd_valid_reg)
                    begin
                        run_next = run_step;
                    end
                    if (!issue && !rd_valid_reg)
                    begin
                        res_failed_next = 1'b1;
                        res_start_next  = '0;
                        state_next      = ST_DONE;
                    end
                end
            end

            ST_MARK:
            begin
                ram_wr_en     = 1'b1;
                ram_wr_addr   = mark_idx_reg;
                ram_wr_data   = {1'b1, id_reg};
                mark_idx_next = mark_idx_reg + IDX_W'(1);
                if (mark_idx_reg == mark_end_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_data_next.start_slot = res_start_reg;
                    rsp_data_next.failed     = res_failed_reg;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            op_reg         <= OP_ALLOC;
            id_reg         <= '0;
            len_reg        <= '0;
            rd_idx_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            rd_addr_reg    <= '0;
            run_reg        <= '0;
            mark_idx_reg   <= '0;
            mark_end_reg   <= '0;
            clr_idx_reg    <= '0;
            res_start_reg  <= '0;
            res_failed_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            id_reg         <= id_next;
            len_reg        <= len_next;
            rd_idx_reg     <= rd_idx_next;
            rd_valid_reg   <= rd_valid_next;
            rd_addr_reg    <= rd_addr_next;
            run_reg        <= run_next;
            mark_idx_reg   <= mark_idx_next;
            mark_end_reg   <= mark_end_next;
            clr_idx_reg    <= clr_idx_next;
            res_start_reg  <= res_start_next;
            res_failed_reg <= res_failed_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_data_reg   <= rsp_data_next;
        end
    end

    // A response beat only appears when the sequencer leaves its done state.
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("response beat raised outside the done state");

    // The allocate scan never writes the slot store.
    a_scan_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && ram_wr_en) |-> (op_reg == OP_FREE))
        else $error("slot store written during an allocate scan");

    // Marking stays inside the active row.
    a_mark_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARK) |-> (CNT_W'(mark_idx_reg) < w_cnt))
        else $error("marking beyond the active row width");

    // The free run count stays below the requested length while scanning.
    a_run_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && (op_reg == OP_ALLOC)) |-> (run_reg < len_ext))
        else $error("free run reached the length without a match");

endmodule

// File: sim/tb_first_fit_run_allocator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_run_allocator_top: testbench of the first-fit run allocator
// Directed and random allocate and free requests are sent under several row
// widths. An internal slot map predicts each allocate response, and responses
// are checked in order while both request and response sides stall at random.
// ----------------------------------------------------------------------------
module tb_first_fit_run_allocator_top;
    import ffra_pkg::*;

    localparam int SLOTS         = 128;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int PRINT_LIMIT   = 100;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [31:0]           pwdata    = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req_data  = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b1;
    rsp_t                  rsp_data;

    rsp_t        placement_q [$];
    logic [7:0]  owner_tab [SLOTS];
    bit          busy_tab [SLOTS];
    logic [7:0]  row_width_cfg  = ROW_WIDTH_RESET;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned ready_hold     = 0;
    int unsigned burst_left     = 1;

    first_fit_run_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (rsp_ready)
        begin
            rsp_ready  <= 1'b0;
            ready_hold <= $urandom_range(0, 12);
        end
        else
        begin
            rsp_ready  <= 1'b1;
            ready_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(0, 20);
        end
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_beat
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (placement_q.size() == 0)
                report_mismatch($sformatf("unexpected beat start_slot=%0d failed=%0b",
                                          rsp_data.start_slot, rsp_data.failed));
            else
            begin
                want = placement_q.pop_front();
                if (rsp_data.start_slot !== want.start_slot)
                    report_mismatch($sformatf("start_slot %0d, expected %0d",
                                              rsp_data.start_slot, want.start_slot));
                if (rsp_data.failed !== want.failed)
                    report_mismatch($sformatf("failed %0b, expected %0b",
                                              rsp_data.failed, want.failed));
            end
        end
    end

    function automatic int unsigned active_span();
        return (row_width_cfg > SLOTS) ? SLOTS : row_width_cfg;
    endfunction

    function automatic bit apply_request(input req_t r, output rsp_t placed);
        int unsigned span;
        int unsigned need;
        int unsigned run;
        int unsigned first;
        bit          found;
        span   = active_span();
        need   = r.run_length;
        placed = '0;
        run    = 0;
        first  = 0;
        found  = 1'b0;
        if (r.opcode == OP_FREE)
        begin
            for (int s = 0; s < span; s++)
                if (busy_tab[s] && owner_tab[s] == r.owner_id)
                    busy_tab[s] = 1'b0;
            return 1'b0;
        end
        if (need == 0)
            return 1'b1;
        for (int s = 0; s < span && !found; s++)
        begin
            run = busy_tab[s] ? 0 : run + 1;
            if (run == need)
            begin
                first = s + 1 - need;
                found = 1'b1;
            end
        end
        if (found)
        begin
            for (int s = first; s < first + need; s++)
            begin
                busy_tab[s]  = 1'b1;
                owner_tab[s] = r.owner_id;
            end
            placed.start_slot = first[6:0];
        end
        else
            placed.failed = 1'b1;
        return 1'b1;
    endfunction

    task automatic send_request(input req_t r);
        rsp_t        placed;
        int unsigned gap;
        req_data  <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_ready !== 1'b1)
            @(posedge clk);
        if (apply_request(r, placed))
            placement_q.push_back(placed);
        burst_left--;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 200)
                                              : $urandom_range(0, 8);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
    endtask

    task automatic send_fields(input logic [0:0] op, input logic [7:0] id,
                               input logic [7:0] len);
        req_t r;
        r.opcode     = op;
        r.owner_id   = id;
        r.run_length = len;
        send_request(r);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (placement_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_row_width(input logic [7:0] w);
        logic [31:0] noise;
        noise = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ROW_WIDTH, 2'b00};
        pwdata  <= {noise[31:8], w};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        row_width_cfg = w;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (prdata[7:0] !== w)
            report_mismatch($sformatf("row_width reads %0d, expected %0d", prdata[7:0], w));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] live_owner();
        logic [7:0]  held [$];
        int unsigned span;
        span = active_span();
        for (int s = 0; s < span; s++)
            if (busy_tab[s])
                held.push_back(owner_tab[s]);
        if (held.size() == 0)
            return 8'($urandom_range(0, 15));
        return held[$urandom_range(0, held.size() - 1)];
    endfunction

    function automatic req_t random_request();
        req_t        r;
        int unsigned span;
        int unsigned pick;
        span = active_span();
        pick = $urandom_range(0, 99);
        r.opcode     = OP_ALLOC;
        r.owner_id   = ($urandom_range(0, 3) == 0) ? 8'($urandom())
                                                   : 8'($urandom_range(0, 15));
        r.run_length = 8'($urandom_range(1, (span > 4) ? span / 4 : 1));
        if (pick < 45)
        begin
            r.opcode     = OP_FREE;
            r.run_length = 8'($urandom());
            if ($urandom_range(0, 4) != 0)
                r.owner_id = live_owner();
        end
        else if (pick < 50)
            r.run_length = 8'd0;
        else if (pick < 60)
            r.run_length = 8'($urandom());
        return r;
    endfunction

    task automatic test_directed_cases();
        send_fields(OP_ALLOC, 8'h00, 8'd0);
        send_fields(OP_ALLOC, 8'hFF, 8'd1);
        send_fields(OP_ALLOC, 8'h01, 8'd128);
        send_fields(OP_ALLOC, 8'hAA, 8'd255);
        send_fields(OP_ALLOC, 8'h55, 8'd127);
        send_fields(OP_ALLOC, 8'h03, 8'd1);
        send_fields(OP_ALLOC, 8'h03, 8'd0);
        send_fields(OP_FREE,  8'hFF, 8'd0);
        send_fields(OP_FREE,  8'h42, 8'd0);
        send_fields(OP_ALLOC, 8'h80, 8'd1);
        send_fields(OP_FREE,  8'h55, 8'd0);
        send_fields(OP_ALLOC, 8'h7F, 8'd64);
        send_fields(OP_ALLOC, 8'h01, 8'd64);
        send_fields(OP_ALLOC, 8'h01, 8'd63);
        send_fields(OP_FREE,  8'h80, 8'hFF);
        send_fields(OP_FREE,  8'h7F, 8'd0);
        send_fields(OP_FREE,  8'h01, 8'd0);
    endtask

    task automatic test_width_extremes();
        wait_idle();
        write_row_width(8'd1);
        send_fields(OP_ALLOC, 8'h11, 8'd1);
        send_fields(OP_ALLOC, 8'h12, 8'd1);
        send_fields(OP_ALLOC, 8'h12, 8'd2);
        wait_idle();
        write_row_width(8'd0);
        send_fields(OP_ALLOC, 8'h12, 8'd1);
        send_fields(OP_ALLOC, 8'h12, 8'd0);
        send_fields(OP_FREE,  8'h11, 8'd0);
        wait_idle();
        write_row_width(8'd255);
        send_fields(OP_ALLOC, 8'h13, 8'd1);
        send_fields(OP_FREE,  8'h11, 8'd0);
        send_fields(OP_FREE,  8'h13, 8'd0);
    endtask

    task automatic test_drain_pause();
        repeat (20) send_request(random_request());
        wait_idle();
        repeat (20) send_request(random_request());
    endtask

    task automatic test_random_traffic();
        logic [7:0]  widths [10];
        int unsigned counts [10];
        widths = '{8'd128, 8'd16, 8'd3, 8'd200, 8'd1,
                   8'($urandom_range(1, 128)), 8'd0, 8'd64,
                   8'($urandom_range(1, 128)), 8'd128};
        counts = '{300, 200, 100, 250, 60, 250, 30, 250, 150, 150};
        for (int p = 0; p < 10; p++)
        begin
            wait_idle();
            write_row_width(widths[p]);
            repeat (counts[p]) send_request(random_request());
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_width_extremes();
        test_drain_pause();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
